FILE: rtl/hbrp_pkg.sv
// Shared types, character codes, phase codes and status codes of the byte-range parser.
package hbrp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 64;

   // Parse phases.
   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_LEAD   = 3'd1;
   localparam logic [2:0] PH_START  = 3'd2;
   localparam logic [2:0] PH_END    = 3'd3;
   localparam logic [2:0] PH_TRAIL  = 3'd4;
   localparam logic [2:0] PH_BAD    = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_IGNORE = 2'd0;
   localparam logic [1:0] ST_UNSAT  = 2'd1;
   localparam logic [1:0] ST_VALID  = 2'd2;

   // Characters.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DASH  = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [7:0] CASE_DELTA = 8'h20;
   localparam logic [2:0] PREFIX_LEN = 3'd6;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [63:0] resource_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  range_status;
      logic [63:0] range_start;
      logic [63:0] range_end;
   } rsp_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       start_seen;
      logic       end_seen;
   } parse_flags_type;

   // Lower-case unit prefix "bytes=", one character per position.
   function automatic logic [7:0] unit_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h62;
         3'd1:    ch = 8'h79;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h65;
         3'd4:    ch = 8'h73;
         3'd5:    ch = 8'h3d;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/hbrp_parse.sv
// Header parse state machine with saturating decimal accumulators.
module hbrp_parse import hbrp_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_valid,
   input  logic [7:0]             header_byte,
   output parse_flags_type        flags,
   output logic [OFFSET_BITS-1:0] start_value,
   output logic [OFFSET_BITS-1:0] end_value
);

   localparam int WideBits = OFFSET_BITS + 4;

   logic [2:0]             phase_ff, phase_in;
   logic [2:0]             prefix_count_ff, prefix_count_in;
   logic [OFFSET_BITS-1:0] start_value_ff, start_value_in;
   logic [OFFSET_BITS-1:0] end_value_ff, end_value_in;
   logic                   start_seen_ff, start_seen_in;
   logic                   end_seen_ff, end_seen_in;
   logic [7:0]             folded;
   logic                   is_digit;

   // Multiply by ten and add the digit; any carry into the top four bits saturates.
   function automatic logic [OFFSET_BITS-1:0] accumulate(input logic [OFFSET_BITS-1:0] acc,
                                                         input logic [3:0] digit);
      logic [WideBits-1:0] wide;
      logic [WideBits-1:0] sum;
      wide = WideBits'(acc);
      sum  = (wide << 3) + (wide << 1) + WideBits'(digit);
      if (sum[WideBits-1 -: 4] != 4'd0) begin
         return '1;
      end
      return sum[OFFSET_BITS-1:0];
   endfunction

   assign is_digit = (header_byte >= CHAR_ZERO) && (header_byte <= CHAR_NINE);
   assign folded   = ((header_byte >= CHAR_UP_A) && (header_byte <= CHAR_UP_Z)) ?
                     header_byte + CASE_DELTA : header_byte;

   always_comb begin
      phase_in        = phase_ff;
      prefix_count_in = prefix_count_ff;
      start_value_in  = start_value_ff;
      end_value_in    = end_value_ff;
      start_seen_in   = start_seen_ff;
      end_seen_in     = end_seen_ff;
      if (step_valid) begin
         if (header_byte == CHAR_NUL) begin
            phase_in        = PH_PREFIX;
            prefix_count_in = 3'd0;
            start_value_in  = '0;
            end_value_in    = '0;
            start_seen_in   = 1'b0;
            end_seen_in     = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_PREFIX: begin
                  if ((prefix_count_ff < PREFIX_LEN) && (folded == unit_char(prefix_count_ff))) begin
                     prefix_count_in = prefix_count_ff + 3'd1;
                     if (prefix_count_in == PREFIX_LEN) begin
                        phase_in = PH_LEAD;
                     end
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_LEAD: begin
                  priority if (header_byte == CHAR_SPACE) begin
                     phase_in = PH_LEAD;
                  end else if (is_digit) begin
                     start_seen_in  = 1'b1;
                     start_value_in = accumulate(start_value_ff, header_byte[3:0]);
                     phase_in       = PH_START;
                  end else if (header_byte == CHAR_DASH) begin
                     phase_in = PH_END;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_START: begin
                  priority if (is_digit) begin
                     start_value_in = accumulate(start_value_ff, header_byte[3:0]);
                  end else if (header_byte == CHAR_DASH) begin
                     phase_in = PH_END;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_END: begin
                  priority if (is_digit) begin
                     end_seen_in  = 1'b1;
                     end_value_in = accumulate(end_value_ff, header_byte[3:0]);
                  end else if (header_byte == CHAR_SPACE) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_TRAIL: begin
                  if (header_byte != CHAR_SPACE) begin
                     phase_in = PH_BAD;
                  end
               end
               default: begin
                  phase_in = PH_BAD;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREFIX;
         prefix_count_ff <= 3'd0;
         start_value_ff  <= '0;
         end_value_ff    <= '0;
         start_seen_ff   <= 1'b0;
         end_seen_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         prefix_count_ff <= prefix_count_in;
         start_value_ff  <= start_value_in;
         end_value_ff    <= end_value_in;
         start_seen_ff   <= start_seen_in;
         end_seen_ff     <= end_seen_in;
      end
   end

   assign flags.phase      = phase_ff;
   assign flags.start_seen = start_seen_ff;
   assign flags.end_seen   = end_seen_ff;
   assign start_value      = start_value_ff;
   assign end_value        = end_value_ff;

endmodule

FILE: rtl/hbrp_resolve.sv
// Resolves the parsed range against the resource size into a result item.
module hbrp_resolve import hbrp_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  parse_flags_type        flags,
   input  logic [OFFSET_BITS-1:0] start_value,
   input  logic [OFFSET_BITS-1:0] end_value,
   input  logic [OFFSET_BITS-1:0] size,
   output rsp_type                result
);

   logic                   start_ge_size;
   logic                   end_ge_size;
   logic                   start_gt_end;
   logic [OFFSET_BITS-1:0] size_minus_one;
   logic [OFFSET_BITS-1:0] size_minus_end;
   logic [1:0]             status;
   logic [OFFSET_BITS-1:0] first;
   logic [OFFSET_BITS-1:0] last;

   // All comparisons run in parallel; the selection below only picks among them.
   assign start_ge_size  = start_value >= size;
   assign end_ge_size    = end_value >= size;
   assign start_gt_end   = start_value > end_value;
   assign size_minus_one = size - OFFSET_BITS'(1);
   assign size_minus_end = size - end_value;

   always_comb begin
      status = ST_VALID;
      first  = start_value;
      last   = end_value;
      priority if ((flags.phase != PH_END) && (flags.phase != PH_TRAIL)) begin
         status = ST_IGNORE;
      end else if (!flags.start_seen) begin
         if (!flags.end_seen || (end_value == '0) || (size == '0)) begin
            status = ST_UNSAT;
         end else begin
            first = end_ge_size ? '0 : size_minus_end;
            last  = size_minus_one;
         end
      end else begin
         priority if (start_ge_size) begin
            status = ST_UNSAT;
         end else if (!flags.end_seen || end_ge_size) begin
            last = size_minus_one;
         end else if (start_gt_end) begin
            status = ST_UNSAT;
         end else begin
            last = end_value;
         end
      end
   end

   assign result.range_status = status;
   assign result.range_start  = (status == ST_VALID) ? 64'(first) : 64'd0;
   assign result.range_end    = (status == ST_VALID) ? 64'(last) : 64'd0;

endmodule

FILE: rtl/http_byte_range_parser_core.sv
// Top level of the HTTP single byte-range header parser.
//
//   Channel   Direction  Handshake               Item
//   req_      in         req_valid / req_stall   one header byte plus resource size
//   rsp_      out        rsp_valid / rsp_stall   status, first and last byte offset
//
// An item is taken in every cycle unless the input register is stalled. It sits in
// the input register, then the parse state machine consumes it and, for the zero
// byte that ends a header, the resolved range is written to the result register.
// Reset clears all parse state and both valid flags; there is no clearing pass.
// A stall on the result side holds only zero bytes at the input register, because
// ordinary header bytes produce no result and keep flowing through the parser.
module http_byte_range_parser_core import hbrp_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic                   result_free;
   logic                   end_of_header;
   logic                   consume;
   logic                   accept;
   parse_flags_type        flags;
   logic [OFFSET_BITS-1:0] start_value;
   logic [OFFSET_BITS-1:0] end_value;
   rsp_type                resolved;

   // The result register can take a new item when it is empty or being emptied.
   assign result_free   = !rsp_valid_ff || !rsp_stall;
   assign end_of_header = in_data_ff.header_byte == CHAR_NUL;

   // The held item is consumed unless it would produce a result with nowhere to go.
   assign consume   = in_valid_ff && (!end_of_header || result_free);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_free) begin
         rsp_valid_in = in_valid_ff && end_of_header;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (result_free) begin
         rsp_data_ff <= resolved;
      end
   end

   hbrp_parse #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (consume),
      .header_byte(in_data_ff.header_byte),
      .flags      (flags),
      .start_value(start_value),
      .end_value  (end_value)
   );

   // The size is taken from the zero byte's item; only its low bits take part.
   hbrp_resolve #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_resolve (
      .flags      (flags),
      .start_value(start_value),
      .end_value  (end_value),
      .size       (in_data_ff.resource_size[OFFSET_BITS-1:0]),
      .result     (resolved)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/hbrp_checker.sv
// Port-level checks of the byte-range parser and their binding to the top level.
module hbrp_checker import hbrp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A result that is not a valid range carries zero offsets.
   a_zero_offsets: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.range_status != ST_VALID) |->
         (rsp_data.range_start == 64'd0) && (rsp_data.range_end == 64'd0))
      else $error("non-range result with non-zero offsets");

   // A valid range never runs backwards.
   a_ordered_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.range_status == ST_VALID) |->
         rsp_data.range_start <= rsp_data.range_end)
      else $error("range start beyond range end");

   // The input only backs up when the result side does.
   a_stall_source: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while results flow freely");

   // No result is shown straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   logic unused_req;
   assign unused_req = req_valid ^ (^req_data);

endmodule

bind http_byte_range_parser_core hbrp_checker u_checker (.*);

FILE: tb/sv/http_byte_range_parser_core_tb.sv
// Self-checking testbench of the HTTP single byte-range header parser core.
`timescale 1ns / 100ps

module http_byte_range_parser_core_tb;
   import hbrp_pkg::*;

   // The block is built at its full offset width. The predictor saturates decimal
   // values at the same width and masks the resource size in the same way.
   localparam int          OFS_BITS      = OFFSET_BITS_DEFAULT;
   localparam logic [63:0] OFFSET_MAX    = {64{1'b1}} >> (64 - OFS_BITS);
   localparam logic [47:0] UNIT_TEXT     = "bytes=";
   localparam int          TOTAL_ITEMS   = 450;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          CYCLE_LIMIT   = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   http_byte_range_parser_core #(.OFFSET_BITS(OFS_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // A row of the directed table: the header text, the resource size given with
   // the terminating zero byte and, where it is obvious, the result typed in.
   typedef struct {
      string       text;
      logic [63:0] size;
      bit          typed;
      rsp_type     want;
   } header_case_type;

   header_case_type directed_cases[$];
   logic [7:0]      hdr_bytes[$];
   rsp_type         pending_ranges[$];

   // Parse state of the predictor, kept in step with the block.
   logic [2:0]  hdr_phase;
   logic [2:0]  prefix_pos;
   logic [63:0] first_offset;
   logic [63:0] last_offset;
   bit          first_given;
   bit          last_given;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_hold_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned header_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned result_count = 0;
   int unsigned status_count[3] = '{0, 0, 0};
   int unsigned cycle_count = 0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void clear_parse_state();
      hdr_phase    = PH_PREFIX;
      prefix_pos   = '0;
      first_offset = '0;
      last_offset  = '0;
      first_given  = 1'b0;
      last_given   = 1'b0;
   endfunction

   // One more decimal digit into an offset, saturating rather than wrapping.
   function automatic logic [63:0] sat_decimal(input logic [63:0] acc, input logic [7:0] ch);
      logic [63:0] digit;
      digit = ch - CHAR_ZERO;
      return (acc > (OFFSET_MAX - digit) / 10) ? OFFSET_MAX : acc * 10 + digit;
   endfunction

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= CHAR_ZERO && ch <= CHAR_NINE;
   endfunction

   // Advances the predicted parse by one accepted item. Returns one when the item
   // ends a header, with the resolved range in resolved.
   function automatic bit predict_header_byte(input req_type hdr_item,
                                              output rsp_type resolved);
      logic [7:0]  ch;
      logic [7:0]  folded;
      logic [63:0] size;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [1:0]  status;
      ch       = hdr_item.header_byte;
      size     = hdr_item.resource_size & OFFSET_MAX;
      resolved = '0;
      if (ch == CHAR_NUL) begin
         lo     = first_offset;
         hi     = last_offset;
         status = ST_VALID;
         if (hdr_phase != PH_END && hdr_phase != PH_TRAIL) begin
            status = ST_IGNORE;
         end else if (!first_given) begin
            // Suffix form: the last hi bytes, clamped to the whole resource.
            if (!last_given || hi == 0 || size == 0) begin
               status = ST_UNSAT;
            end else begin
               lo = (hi >= size) ? 64'd0 : size - hi;
               hi = size - 1;
            end
         end else if (lo >= size) begin
            status = ST_UNSAT;
         end else begin
            if (!last_given || hi >= size) hi = size - 1;
            if (lo > hi) status = ST_UNSAT;
         end
         resolved.range_status = status;
         if (status == ST_VALID) begin
            resolved.range_start = lo;
            resolved.range_end   = hi;
         end
         clear_parse_state();
         return 1'b1;
      end
      case (hdr_phase)
         PH_PREFIX: begin
            // Only plain upper-case ASCII letters are folded.
            folded = (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) ? ch + CASE_DELTA : ch;
            if (prefix_pos < PREFIX_LEN && folded == UNIT_TEXT[8 * (5 - prefix_pos) +: 8]) begin
               prefix_pos = prefix_pos + 1;
               if (prefix_pos == PREFIX_LEN) hdr_phase = PH_LEAD;
            end else begin
               hdr_phase = PH_BAD;
            end
         end
         PH_LEAD: begin
            if (ch == CHAR_SPACE) begin
               hdr_phase = PH_LEAD;
            end else if (is_digit(ch)) begin
               first_given  = 1'b1;
               first_offset = sat_decimal(first_offset, ch);
               hdr_phase    = PH_START;
            end else if (ch == CHAR_DASH) begin
               hdr_phase = PH_END;
            end else begin
               hdr_phase = PH_BAD;
            end
         end
         PH_START: begin
            if (is_digit(ch)) first_offset = sat_decimal(first_offset, ch);
            else if (ch == CHAR_DASH) hdr_phase = PH_END;
            else hdr_phase = PH_BAD;
         end
         PH_END: begin
            if (is_digit(ch)) begin
               last_given  = 1'b1;
               last_offset = sat_decimal(last_offset, ch);
            end else if (ch == CHAR_SPACE) begin
               hdr_phase = PH_TRAIL;
            end else begin
               hdr_phase = PH_BAD;
            end
         end
         PH_TRAIL: begin
            if (ch != CHAR_SPACE) hdr_phase = PH_BAD;
         end
         default: hdr_phase = PH_BAD;
      endcase
      return 1'b0;
   endfunction

   task automatic add_case(input string text, input logic [63:0] size, input bit typed,
                           input logic [1:0] status, input logic [63:0] lo,
                           input logic [63:0] hi);
      header_case_type row;
      row.text              = text;
      row.size              = size;
      row.typed             = typed;
      row.want.range_status = status;
      row.want.range_start  = lo;
      row.want.range_end    = hi;
      directed_cases.push_back(row);
   endtask

   task automatic append_text(input string text);
      for (int i = 0; i < text.len(); i++) hdr_bytes.push_back(text[i]);
   endtask

   // Decimal text of an offset, now and then with leading zeros.
   task automatic append_number(input logic [63:0] value);
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(1, 3)) hdr_bytes.push_back(CHAR_ZERO);
      end
      append_text($sformatf("%0d", value));
   endtask

   // An offset picked to land around the resource size, or far past the
   // largest value so that the digits saturate.
   task automatic append_offset(input logic [63:0] size);
      case ($urandom_range(9))
         0: begin
            repeat ($urandom_range(20, 26))
               hdr_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
         end
         1: append_number(size);
         2: append_number(size - 1);
         3: append_number(rand64() & OFFSET_MAX);
         default: append_number((size == 0) ? 64'($urandom_range(50)) : rand64() % size);
      endcase
   endtask

   // Sends the bytes gathered in hdr_bytes followed by the zero byte that ends the
   // header. Every accepted item goes through the predictor; where the item ends
   // a header its result is queued, or the typed-in one if the row gives it.
   // The idling pattern moves on every three headers, so that each pattern is
   // seen several times over the directed and the random headers alike.
   task automatic send_header(input logic [63:0] size, input bit typed, input rsp_type want);
      req_type hdr_item;
      rsp_type predicted;
      bit      produced;
      case ((header_count / 3) % 4)
         0: begin send_idle_pct = 0;  rsp_hold_pct = 0;  end
         1: begin send_idle_pct = 57; rsp_hold_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_hold_pct = 57; end
         default: begin send_idle_pct = 13; rsp_hold_pct = 13; end
      endcase
      hdr_bytes.push_back(CHAR_NUL);
      foreach (hdr_bytes[i]) begin
         hdr_item.header_byte   = hdr_bytes[i];
         hdr_item.resource_size = (hdr_bytes[i] == CHAR_NUL) ? size : rand64();
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= hdr_item;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         produced = predict_header_byte(hdr_item, predicted);
         if (produced) pending_ranges.push_back(typed ? want : predicted);
         bytes_sent++;
      end
      hdr_bytes.delete();
      header_count++;
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at result %0d: %s", result_count, what);
      mismatch_count++;
   endtask

   // Result side: each accepted item is compared field by field with the oldest
   // expectation, and the stall is redrawn every cycle at the current rate.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ranges.size() == 0) begin
               report_mismatch($sformatf("result with no header pending, status %0d",
                                         rsp_data.range_status));
            end else begin
               if (rsp_data.range_status != pending_ranges[0].range_status)
                  report_mismatch($sformatf("range_status %0d, expected %0d",
                                            rsp_data.range_status,
                                            pending_ranges[0].range_status));
               if (rsp_data.range_start != pending_ranges[0].range_start)
                  report_mismatch($sformatf("range_start %0h, expected %0h",
                                            rsp_data.range_start,
                                            pending_ranges[0].range_start));
               if (rsp_data.range_end != pending_ranges[0].range_end)
                  report_mismatch($sformatf("range_end %0h, expected %0h",
                                            rsp_data.range_end,
                                            pending_ranges[0].range_end));
               void'(pending_ranges.pop_front());
            end
            if (rsp_data.range_status <= ST_VALID) status_count[rsp_data.range_status]++;
            result_count++;
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   // Watchdog: a run that hangs ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results pending.",
                  cycle_count, pending_ranges.size());
         $display("http_byte_range_parser_core_tb failed");
         $finish;
      end
   end

   initial begin
      logic [63:0] size;
      int unsigned pick;
      int unsigned prefix_len;
      int unsigned shape;
      logic [7:0]  ch;
      rsp_type     none;

      none = '0;
      clear_parse_state();

      // Synchronous reset, asserted this once only.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed headers. Rows with the result typed in are the ones that can be
      // read straight off the rules; the rest are left to the predictor.
      add_case("bytes=0-0", 64'd1, 1, ST_VALID, 64'd0, 64'd0);
      add_case("BYTES=0-", 64'd0, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=-", 64'd100, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=-0", 64'd100, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=-50", 64'd20, 1, ST_VALID, 64'd0, 64'd19);
      add_case("bytes=-5 ", 64'd3, 0, ST_VALID, 64'd0, 64'd0);
      add_case("bytes=-5", 64'd0, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=10-5", 64'd100, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=5-1000", 64'd100, 1, ST_VALID, 64'd5, 64'd99);
      add_case("bytes=100-", 64'd100, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bYtEs=  7-9  ", 64'd10, 1, ST_VALID, 64'd7, 64'd9);
      add_case("bytes=0-1,2-3", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=5", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("byte", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytez=0-1", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("\302YTES=0-1", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=/0-1", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=0-1:", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=0 -1", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=1-2 3", 64'd100, 1, ST_IGNORE, 64'd0, 64'd0);
      add_case("bytes=99999999999999999999999-", OFFSET_MAX, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=-99999999999999999999999", OFFSET_MAX, 1, ST_VALID, 64'd0,
               OFFSET_MAX - 1);
      add_case("bytes=18446744073709551615-", OFFSET_MAX, 1, ST_UNSAT, 64'd0, 64'd0);
      add_case("bytes=18446744073709551614-", OFFSET_MAX, 0, ST_VALID, 64'd0, 64'd0);
      add_case("bytes=-18446744073709551616", 64'd5, 1, ST_VALID, 64'd0, 64'd4);

      foreach (directed_cases[i]) begin
         append_text(directed_cases[i].text);
         send_header(directed_cases[i].size, directed_cases[i].typed, directed_cases[i].want);
      end

      // Random headers until the whole run has sent its share of bytes. Most are
      // well formed with random case, spacing, forms and offsets around the size;
      // the rest are truncated or mistyped prefixes, stray characters and noise.
      while (bytes_sent < TOTAL_ITEMS) begin
         case ($urandom_range(9))
            0: size = '0;
            1: size = OFFSET_MAX;
            2, 3: size = rand64();
            default: size = 64'($urandom_range(1, 2000));
         endcase

         pick = $urandom_range(99);
         if (pick < 6) begin
            repeat ($urandom_range(10)) hdr_bytes.push_back(8'($urandom_range(1, 255)));
         end else begin
            prefix_len = (pick < 10) ? $urandom_range(5) : 6;
            for (int i = 0; i < prefix_len; i++) begin
               ch = UNIT_TEXT[8 * (5 - i) +: 8];
               if (i < 5 && $urandom_range(1)) ch = ch - CASE_DELTA;
               if (pick < 14 && i == prefix_len - 1) ch = ch ^ (8'd1 << $urandom_range(7));
               hdr_bytes.push_back(ch);
            end
            if (prefix_len == 6) begin
               if ($urandom_range(3) == 0) begin
                  repeat ($urandom_range(1, 2)) hdr_bytes.push_back(CHAR_SPACE);
               end
               shape = $urandom_range(9);
               if (shape <= 6) append_offset(size);
               if (shape != 9 || $urandom_range(1)) hdr_bytes.push_back(CHAR_DASH);
               if (shape <= 4 || shape == 7 || shape == 8) append_offset(size);
               if ($urandom_range(3) == 0) begin
                  repeat ($urandom_range(1, 3)) hdr_bytes.push_back(CHAR_SPACE);
               end
               // A stray character somewhere in an otherwise good header.
               if ($urandom_range(99) < 12) begin
                  ch = $urandom_range(1) ? 8'h2c : 8'($urandom_range(1, 255));
                  hdr_bytes.insert($urandom_range(hdr_bytes.size()), ch);
               end
            end
         end
         send_header(size, 1'b0, none);
      end

      req_valid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Parsed %0d headers from %0d header bytes, %0d cycles.",
               header_count, bytes_sent, cycle_count);
      $display("Results: %0d ignored, %0d unsatisfiable, %0d valid ranges; %0d mismatches.",
               status_count[0], status_count[1], status_count[2], mismatch_count);
      if (mismatch_count == 0) begin
         $display("http_byte_range_parser_core_tb passed");
      end else begin
         $display("http_byte_range_parser_core_tb failed");
      end
      $finish;
   end

endmodule
